// ===== hdl/mand_pkg.sv =====
// shared types and constants for the mandelbrot escape-time pixel engine
// fixed-point widths, register indexes, sequencer states and shade codes; no dependencies
package mand_pkg;

   localparam int INDEX_BITS    = 10;
   localparam int FRACTION_BITS = 28;
   localparam int COUNT_BITS    = 16;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LIMIT_BITS     = 16;
   localparam int COUNT_OUT_BITS = 16;
   localparam int SHADE_BITS     = 3;

   // multiplier operands hold a step magnitude or a z magnitude up to 2.0
   localparam int MUL_BITS  = (FRACTION_BITS + 2 > CSR_DATA_BITS) ? FRACTION_BITS + 2
                                                                   : CSR_DATA_BITS;
   localparam int PROD_BITS = 2 * MUL_BITS;
   // c = origin + index * step, exact
   localparam int C_BITS    = CSR_DATA_BITS + INDEX_BITS + 1;
   // truncated square, sum of squares, truncated doubled cross product
   localparam int SQ_BITS   = FRACTION_BITS + 3;
   localparam int SUM_BITS  = FRACTION_BITS + 4;
   localparam int PXY_BITS  = FRACTION_BITS + 4;
   localparam int Z_BITS    = ((FRACTION_BITS + 5 > C_BITS) ? FRACTION_BITS + 5 : C_BITS) + 1;

   localparam logic [Z_BITS-1:0]   ESC_TWO  = Z_BITS'(2) << FRACTION_BITS;
   localparam logic [SUM_BITS-1:0] ESC_FOUR = SUM_BITS'(4) << FRACTION_BITS;

   localparam logic [SHADE_BITS-1:0] SHADE_DOT    = 3'd0;
   localparam logic [SHADE_BITS-1:0] SHADE_COMMA  = 3'd1;
   localparam logic [SHADE_BITS-1:0] SHADE_TILDE  = 3'd2;
   localparam logic [SHADE_BITS-1:0] SHADE_DASH   = 3'd3;
   localparam logic [SHADE_BITS-1:0] SHADE_INSIDE = 3'd4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_ORIGIN        = 3'd0,
      CSR_X_STEP          = 3'd1,
      CSR_Y_ORIGIN        = 3'd2,
      CSR_Y_STEP          = 3'd3,
      CSR_ITERATION_LIMIT = 3'd4,
      CSR_SHADE_HIGH      = 3'd5,
      CSR_SHADE_MID       = 3'd6,
      CSR_SHADE_LOW       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [CSR_DATA_BITS-1:0] x_origin;
      logic signed [CSR_DATA_BITS-1:0] x_step;
      logic signed [CSR_DATA_BITS-1:0] y_origin;
      logic signed [CSR_DATA_BITS-1:0] y_step;
      logic [LIMIT_BITS-1:0]           iteration_limit;
      logic [LIMIT_BITS-1:0]           shade_high;
      logic [LIMIT_BITS-1:0]           shade_mid;
      logic [LIMIT_BITS-1:0]           shade_low;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_X,
      ST_LOAD_Y,
      ST_FINISH_C,
      ST_TEST,
      ST_SQ_Y,
      ST_CROSS,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time pixel engine. A request beat carries a pixel column and row; the
// block forms c = origin + index * step in signed Q4.28, iterates z = z*z + c from zero
// while |z|^2 <= 4 and the count is below the iteration limit, and returns one response
// beat with the escape count and a shade class (4 inside the set, else 3..0 against the
// high, mid and low thresholds). All arithmetic runs on one 32x32 multiplier with a
// registered product, which is used three times per iteration (zx^2, zy^2, zx*zy); each
// iteration steps through ST_TEST, ST_SQ_Y, ST_CROSS and ST_CHECK, and a pixel stops
// on the limit, on the magnitude test or when the sum of squares escapes. The default
// iteration limit is 1000.
// The engine holds one pixel at a time; a finished result waits in the response register
// so the next request can be taken as soon as the previous one is handed over.
// The user must write registers through the csr port only while the engine is idle; the block does not enforce it.
// depends on mand_pkg; instantiates mand_csr and mand_core
module mandelbrot_escape_time_pixel (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [mand_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mand_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mand_pkg::INDEX_BITS-1:0]        req_column,
   input  logic [mand_pkg::INDEX_BITS-1:0]        req_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mand_pkg::COUNT_OUT_BITS-1:0]    rsp_escape_count,
   output logic [mand_pkg::SHADE_BITS-1:0]        rsp_shade
);
   import mand_pkg::*;

   cfg_type                   cfg;
   logic                      res_valid;
   logic                      res_ready;
   logic [COUNT_OUT_BITS-1:0] res_count;
   logic [SHADE_BITS-1:0]     res_shade;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [SHADE_BITS-1:0]     rsp_shade_ff, rsp_shade_in;

   mand_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mand_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_column (req_column),
      .req_row    (req_row),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_count  (res_count),
      .res_shade  (res_shade)
   );

   // output register takes a new beat when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_shade_in = rsp_shade_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_count_in = res_count;
            rsp_shade_in = res_shade;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_shade_ff <= rsp_shade_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;
   assign rsp_shade        = rsp_shade_ff;

endmodule

// ===== hdl/mand_csr.sv =====
// configuration register file of the mandelbrot pixel engine
// depends on mand_pkg for the register indexes and the cfg_type bundle
module mand_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mand_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mand_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output mand_pkg::cfg_type                     cfg
);
   import mand_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_ORIGIN:        cfg_in.x_origin        = csr_wdata;
            CSR_X_STEP:          cfg_in.x_step          = csr_wdata;
            CSR_Y_ORIGIN:        cfg_in.y_origin        = csr_wdata;
            CSR_Y_STEP:          cfg_in.y_step          = csr_wdata;
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_wdata[LIMIT_BITS-1:0];
            CSR_SHADE_HIGH:      cfg_in.shade_high      = csr_wdata[LIMIT_BITS-1:0];
            CSR_SHADE_MID:       cfg_in.shade_mid       = csr_wdata[LIMIT_BITS-1:0];
            CSR_SHADE_LOW:       cfg_in.shade_low       = csr_wdata[LIMIT_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin        <= -32'sd536870912;
         cfg_ff.x_step          <= '0;
         cfg_ff.y_origin        <= 32'sd536870912;
         cfg_ff.y_step          <= '0;
         cfg_ff.iteration_limit <= 16'd1000;
         cfg_ff.shade_high      <= 16'd800;
         cfg_ff.shade_mid       <= 16'd600;
         cfg_ff.shade_low       <= 16'd400;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mand_mul.sv =====
// shared unsigned multiplier with a registered product
// depends on mand_pkg for the operand width
module mand_mul (
   input  logic                             clock,
   input  logic [mand_pkg::MUL_BITS-1:0]    mul_a,
   input  logic [mand_pkg::MUL_BITS-1:0]    mul_b,
   output logic [mand_pkg::PROD_BITS-1:0]   product
);
   import mand_pkg::*;

   logic [PROD_BITS-1:0] product_ff;
   logic [PROD_BITS-1:0] product_in;

   assign product_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== hdl/mand_core.sv =====
// sequencer and datapath: forms c, then iterates z = z*z + c on the shared multiplier
// depends on mand_pkg and instantiates mand_mul
module mand_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mand_pkg::cfg_type                      cfg,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mand_pkg::INDEX_BITS-1:0]        req_column,
   input  logic [mand_pkg::INDEX_BITS-1:0]        req_row,
   output logic                                   res_valid,
   input  logic                                   res_ready,
   output logic [mand_pkg::COUNT_OUT_BITS-1:0]    res_count,
   output logic [mand_pkg::SHADE_BITS-1:0]        res_shade
);
   import mand_pkg::*;

   state_type state_ff, state_in;

   logic [INDEX_BITS-1:0]    column_ff, column_in;
   logic [INDEX_BITS-1:0]    row_ff, row_in;
   logic signed [C_BITS-1:0] cx_ff, cx_in;
   logic signed [C_BITS-1:0] cy_ff, cy_in;
   logic signed [Z_BITS-1:0] zx_ff, zx_in;
   logic signed [Z_BITS-1:0] zy_ff, zy_in;
   logic [SQ_BITS-1:0]       sx_ff, sx_in;
   logic [SQ_BITS-1:0]       sy_ff, sy_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   logic [MUL_BITS-1:0]      mul_a, mul_b;
   logic [PROD_BITS-1:0]     product;

   logic [Z_BITS-1:0]        mag_x, mag_y;
   logic [COUNT_BITS-1:0]    limit;
   logic [SUM_BITS-1:0]      sum_sq;
   logic [PXY_BITS-1:0]      pxy;
   logic signed [Z_BITS-1:0] pxy_signed;
   logic                     cross_neg;

   // step magnitude for the unsigned multiplier
   function automatic logic [MUL_BITS-1:0] step_mag(input logic signed [CSR_DATA_BITS-1:0] s);
      logic [CSR_DATA_BITS-1:0] m;
      m = s[CSR_DATA_BITS-1] ? CSR_DATA_BITS'(-s) : CSR_DATA_BITS'(s);
      return MUL_BITS'(m);
   endfunction

   // origin plus signed index product
   function automatic logic signed [C_BITS-1:0] form_c(
      input logic signed [CSR_DATA_BITS-1:0] origin,
      input logic                            neg,
      input logic [PROD_BITS-1:0]            p
   );
      logic signed [C_BITS-1:0] term;
      term = $signed({1'b0, p[C_BITS-2:0]});
      return C_BITS'(origin) + (neg ? -term : term);
   endfunction

   mand_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign mag_x  = zx_ff[Z_BITS-1] ? Z_BITS'(-zx_ff) : Z_BITS'(zx_ff);
   assign mag_y  = zy_ff[Z_BITS-1] ? Z_BITS'(-zy_ff) : Z_BITS'(zy_ff);
   assign limit  = COUNT_BITS'(cfg.iteration_limit);
   assign sum_sq = SUM_BITS'(sx_ff) + SUM_BITS'(sy_ff);
   assign pxy    = product[FRACTION_BITS-1 +: PXY_BITS];
   assign pxy_signed = $signed(Z_BITS'(pxy));
   // sign of 2*zx*zy comes from z before the update
   assign cross_neg  = zx_ff[Z_BITS-1] != zy_ff[Z_BITS-1];

   always_comb begin
      state_in  = state_ff;
      column_in = column_ff;
      row_in    = row_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      zx_in     = zx_ff;
      zy_in     = zy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      count_in  = count_ff;
      mul_a     = '0;
      mul_b     = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res_shade = SHADE_DOT;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               column_in = req_column;
               row_in    = req_row;
               state_in  = ST_LOAD_X;
            end
         end
         ST_LOAD_X: begin
            mul_a    = step_mag(cfg.x_step);
            mul_b    = MUL_BITS'(column_ff);
            state_in = ST_LOAD_Y;
         end
         ST_LOAD_Y: begin
            mul_a    = step_mag(cfg.y_step);
            mul_b    = MUL_BITS'(row_ff);
            cx_in    = form_c(cfg.x_origin, cfg.x_step[CSR_DATA_BITS-1], product);
            state_in = ST_FINISH_C;
         end
         ST_FINISH_C: begin
            cy_in    = form_c(cfg.y_origin, cfg.y_step[CSR_DATA_BITS-1], product);
            zx_in    = '0;
            zy_in    = '0;
            count_in = '0;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            mul_a = MUL_BITS'(mag_x);
            mul_b = MUL_BITS'(mag_x);
            if (count_ff >= limit || mag_x > ESC_TWO || mag_y > ESC_TWO) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_Y;
            end
         end
         ST_SQ_Y: begin
            mul_a    = MUL_BITS'(mag_y);
            mul_b    = MUL_BITS'(mag_y);
            sx_in    = product[FRACTION_BITS +: SQ_BITS];
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            mul_a    = MUL_BITS'(mag_x);
            mul_b    = MUL_BITS'(mag_y);
            sy_in    = product[FRACTION_BITS +: SQ_BITS];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sum_sq > ESC_FOUR) begin
               state_in = ST_DONE;
            end else begin
               zx_in    = $signed(Z_BITS'(sx_ff)) - $signed(Z_BITS'(sy_ff))
                          + Z_BITS'(cx_ff);
               zy_in    = (cross_neg ? -pxy_signed : pxy_signed) + Z_BITS'(cy_ff);
               count_in = count_ff + COUNT_BITS'(1);
               state_in = ST_TEST;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            priority if (count_ff == limit) begin
               res_shade = SHADE_INSIDE;
            end else if (32'(count_ff) > 32'(cfg.shade_high)) begin
               res_shade = SHADE_DASH;
            end else if (32'(count_ff) > 32'(cfg.shade_mid)) begin
               res_shade = SHADE_TILDE;
            end else if (32'(count_ff) > 32'(cfg.shade_low)) begin
               res_shade = SHADE_COMMA;
            end else begin
               res_shade = SHADE_DOT;
            end
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign res_count = COUNT_OUT_BITS'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff <= column_in;
      row_ff    <= row_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      zx_ff     <= zx_in;
      zy_ff     <= zy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      count_ff  <= count_in;
   end

endmodule
